// File: hdl/feal4_pkg.sv
// Shared types, constants and the FEAL round function for the FEAL-4 cipher.
// No dependencies; every other file in hdl/ uses this package.
package feal4_pkg;

   localparam int NUM_ROUNDS  = 4;
   localparam int NUM_SUBKEYS = 6;
   localparam int WORD_W      = 32;
   localparam int CSR_INDEX_W = 3;

   // Register map of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      SUBKEY_0 = 3'd0,
      SUBKEY_1 = 3'd1,
      SUBKEY_2 = 3'd2,
      SUBKEY_3 = 3'd3,
      SUBKEY_4 = 3'd4,
      SUBKEY_5 = 3'd5
   } csr_index_type;

   // Operation codes
   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef logic [WORD_W-1:0] word_type;

   // Pipeline payload. Encryption and decryption share one round form:
   // active' = other ^ F(active ^ key), other' = active.
   typedef struct packed {
      op_type   op;
      word_type active;
      word_type other;
   } stage_type;

   function automatic logic [7:0] rot2(logic [7:0] v);
      return {v[5:0], v[7:6]};
   endfunction

   function automatic word_type feal_f(word_type x);
      logic [7:0] x0, x1, x2, x3, m, y0, y1, y2, y3;
      x0 = x[31:24];
      x1 = x[23:16];
      x2 = x[15:8];
      x3 = x[7:0];
      m  = x2 ^ x3;
      y1 = rot2((x0 ^ x1) + m + 8'd1);
      y0 = rot2(x0 + y1);
      y2 = rot2(y1 + m);
      y3 = rot2(y2 + x3 + 8'd1);
      return {y0, y1, y2, y3};
   endfunction

endpackage

// File: hdl/feal4_if.sv
// Channel interfaces for the FEAL-4 cipher: request, response, configuration.
// Depends on feal4_pkg.
interface feal4_req_if;
   logic                   valid;
   logic                   ready;
   logic                   operation;
   feal4_pkg::word_type    block_high;
   feal4_pkg::word_type    block_low;

   modport source (output valid, output operation, output block_high, output block_low,
                   input ready);
   modport sink   (input valid, input operation, input block_high, input block_low,
                   output ready);
endinterface

interface feal4_rsp_if;
   logic                   valid;
   logic                   ready;
   feal4_pkg::word_type    result_high;
   feal4_pkg::word_type    result_low;

   modport source (output valid, output result_high, output result_low, input ready);
   modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

interface feal4_csr_if;
   logic                                valid;
   logic                                ready;
   logic [feal4_pkg::CSR_INDEX_W-1:0]   index;
   feal4_pkg::word_type                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/feal4_block_cipher.sv
// FEAL-4 block cipher, fully pipelined. Takes one 64-bit block per cycle
// unless stalled, encrypt or decrypt chosen per transaction, and returns one
// block per transaction in order. There are six register stages: an input
// whitening register, one register per round (four rounds, each one FEAL F
// evaluation of byte adds and rotates), and the output register. The
// whitening register captures at the edge that accepts the request; the
// transaction then passes the four round registers and the output register.
// Sustained rate is one transaction per cycle; a full stage holds its
// contents while the stage after it cannot take them, and the request side
// keeps accepting as long as some stage ahead has room. The six 32-bit
// subkeys are written through the configuration channel (index 0..5, other
// indexes ignored, all reset to zero); write them only while no transaction
// is in flight. Depends on feal4_pkg, feal4_if, feal4_csr and feal4_round.
module feal4_block_cipher (
   input  logic        clock,
   input  logic        reset,
   feal4_req_if.sink   req_if,
   feal4_rsp_if.source rsp_if,
   feal4_csr_if.sink   csr_if
);

   localparam int NR = feal4_pkg::NUM_ROUNDS;

   feal4_pkg::word_type subkey [feal4_pkg::NUM_SUBKEYS];

   // stage k is produced by the input register (k = 0) or round k (k > 0);
   // stg_ready[k] comes from whoever consumes stage k
   logic                 stg_valid [NR+1];
   logic                 stg_ready [NR+1];
   feal4_pkg::stage_type stg_data  [NR+1];

   feal4_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .subkey (subkey)
   );

   // ---------------- input whitening stage ----------------
   // encrypt: active = hi ^ lo,            other = hi
   // decrypt: active = hi ^ k4 ^ lo ^ k5,  other = hi ^ k4
   logic                 prep_valid_ff, prep_valid_in;
   feal4_pkg::stage_type prep_data_ff, prep_data_in;
   feal4_pkg::word_type  hi_w;

   assign req_if.ready = !prep_valid_ff || stg_ready[0];

   always_comb begin
      if (req_if.operation) begin
         prep_data_in.op = feal4_pkg::OP_DECRYPT;
         hi_w = req_if.block_high ^ subkey[4];
         prep_data_in.active = hi_w ^ req_if.block_low ^ subkey[5];
      end else begin
         prep_data_in.op = feal4_pkg::OP_ENCRYPT;
         hi_w = req_if.block_high;
         prep_data_in.active = hi_w ^ req_if.block_low;
      end
      prep_data_in.other = hi_w;
      prep_valid_in = req_if.ready ? req_if.valid : prep_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         prep_data_ff <= prep_data_in;
      end
   end

   assign stg_valid[0] = prep_valid_ff;
   assign stg_data[0]  = prep_data_ff;

   // ---------------- four round stages ----------------
   // decryption walks the subkeys in reverse order
   for (genvar g = 0; g < NR; g++) begin : g_round
      feal4_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_data   (stg_data[g]),
         .enc_key   (subkey[g]),
         .dec_key   (subkey[NR-1-g]),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_data  (stg_data[g+1])
      );
   end

   // ---------------- output stage ----------------
   // encrypt: high = active ^ k4, low = other ^ active ^ k5
   // decrypt: high = active,      low = other ^ active
   logic                rsp_valid_ff, rsp_valid_in;
   feal4_pkg::word_type rsp_high_ff, rsp_high_in;
   feal4_pkg::word_type rsp_low_ff, rsp_low_in;
   feal4_pkg::stage_type last;

   assign last         = stg_data[NR];
   assign stg_ready[NR] = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      if (last.op == feal4_pkg::OP_DECRYPT) begin
         rsp_high_in = last.active;
         rsp_low_in  = last.other ^ last.active;
      end else begin
         rsp_high_in = last.active ^ subkey[4];
         rsp_low_in  = last.other ^ last.active ^ subkey[5];
      end
      rsp_valid_in = stg_ready[NR] ? stg_valid[NR] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[NR]) begin
         rsp_high_ff <= rsp_high_in;
         rsp_low_ff  <= rsp_low_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_high = rsp_high_ff;
   assign rsp_if.result_low  = rsp_low_ff;

endmodule

// File: hdl/feal4_csr.sv
// Subkey register file written over the configuration channel.
// Depends on feal4_pkg and feal4_csr_if.
module feal4_csr (
   input  logic                 clock,
   input  logic                 reset,
   feal4_csr_if.sink            csr_if,
   output feal4_pkg::word_type  subkey [feal4_pkg::NUM_SUBKEYS]
);

   feal4_pkg::word_type subkey_ff [feal4_pkg::NUM_SUBKEYS];
   feal4_pkg::word_type subkey_in [feal4_pkg::NUM_SUBKEYS];

   assign csr_if.ready = 1'b1;

   always_comb begin
      subkey_in = subkey_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            feal4_pkg::SUBKEY_0: subkey_in[0] = csr_if.data;
            feal4_pkg::SUBKEY_1: subkey_in[1] = csr_if.data;
            feal4_pkg::SUBKEY_2: subkey_in[2] = csr_if.data;
            feal4_pkg::SUBKEY_3: subkey_in[3] = csr_if.data;
            feal4_pkg::SUBKEY_4: subkey_in[4] = csr_if.data;
            feal4_pkg::SUBKEY_5: subkey_in[5] = csr_if.data;
            default:             ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < feal4_pkg::NUM_SUBKEYS; i++) begin
            subkey_ff[i] <= '0;
         end
      end else begin
         subkey_ff <= subkey_in;
      end
   end

   assign subkey = subkey_ff;

endmodule

// File: hdl/feal4_round.sv
// One registered FEAL round stage with valid/ready flow control.
// Depends on feal4_pkg.
module feal4_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  feal4_pkg::stage_type  in_data,
   input  feal4_pkg::word_type   enc_key,
   input  feal4_pkg::word_type   dec_key,
   output logic                  out_valid,
   input  logic                  out_ready,
   output feal4_pkg::stage_type  out_data
);

   logic                 valid_ff, valid_in;
   feal4_pkg::stage_type data_ff, data_in;
   feal4_pkg::word_type  key;

   // stage takes a new transaction when empty or when its contents move on
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      key = (in_data.op == feal4_pkg::OP_DECRYPT) ? dec_key : enc_key;
      data_in.op     = in_data.op;
      data_in.active = in_data.other ^ feal4_pkg::feal_f(in_data.active ^ key);
      data_in.other  = in_data.active;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
